@@ design/sepg_pkg.sv @@
// ----------------------------------------------------------------------------
// sepg_pkg
// Shared types, constants and helper functions of the strip scanner eye
// pattern generator.
// ----------------------------------------------------------------------------
package sepg_pkg;

  localparam int STRIP_LENGTH = 64;
  localparam int PIX_W        = $clog2(STRIP_LENGTH);
  localparam int NUM_W        = ((PIX_W > 6) ? PIX_W : 6) + 2;
  localparam int IDX_W        = 6;
  localparam int COLOR_W      = 8;
  localparam int EYE_W_BITS   = 6;
  localparam int HOLD_W       = 16;
  localparam int HOLD_OUT_W   = 17;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;
  localparam int NUM_SWEEPS   = 8;
  localparam int SWEEP_W      = 3;
  localparam int RESET_EYE_W  = 4;

  typedef logic signed [NUM_W-1:0] num_t;

  typedef enum logic [1:0] {
    KIND_RL = 2'd0,
    KIND_LR = 2'd1,
    KIND_OC = 2'd2,
    KIND_CO = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    SHADE_BLACK = 2'd0,
    SHADE_DIM   = 2'd1,
    SHADE_FULL  = 2'd2
  } shade_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EYE_RED      = 3'd0,
    CFG_EYE_GREEN    = 3'd1,
    CFG_EYE_BLUE     = 3'd2,
    CFG_EYE_WIDTH    = 3'd3,
    CFG_STEP_HOLD    = 3'd4,
    CFG_SWEEP_HOLD   = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    num_t                  pix;
    num_t                  pos;
    num_t                  width;
    logic                  mirrored;
    logic                  frame_end;
    logic                  seq_end;
    logic [HOLD_OUT_W-1:0] hold;
  } step_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } color_t;

  function automatic kind_t sweep_kind(input logic [SWEEP_W-1:0] s);
    kind_t k;
    case (s)
      3'd0:    k = KIND_RL;
      3'd1:    k = KIND_LR;
      3'd2:    k = KIND_OC;
      3'd3:    k = KIND_CO;
      3'd4:    k = KIND_LR;
      3'd5:    k = KIND_RL;
      3'd6:    k = KIND_OC;
      default: k = KIND_CO;
    endcase
    return k;
  endfunction

  function automatic num_t sweep_start(input kind_t k, input num_t w);
    num_t r;
    case (k)
      KIND_RL: r = num_t'(STRIP_LENGTH - 2) - w;
      KIND_CO: r = (num_t'(STRIP_LENGTH) - w) >>> 1;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic last_frame(input kind_t k, input num_t w, input num_t pos);
    logic r;
    case (k)
      KIND_RL: r = (pos <= num_t'(1));
      KIND_LR: r = (pos >= num_t'(STRIP_LENGTH - 3) - w);
      KIND_OC: r = (pos >= ((num_t'(STRIP_LENGTH) - w) >>> 1));
      default: r = (pos <= num_t'(0));
    endcase
    return r;
  endfunction

  // x / 10 for 8-bit x as a reciprocal multiply, exact over the whole range
  function automatic logic [COLOR_W-1:0] div10(input logic [COLOR_W-1:0] x);
    logic [15:0] prod;
    prod = 16'(x) * 16'd205;
    return COLOR_W'(prod[15:11]);
  endfunction

endpackage

@@ design/sepg_sequencer.sv @@
// ----------------------------------------------------------------------------
// sepg_sequencer
// Sweep, eye position and pixel counters; frame and sweep end detection and
// the frame hold time.
// ----------------------------------------------------------------------------
module sepg_sequencer import sepg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic                  restart,
  input  logic [EYE_W_BITS-1:0] eye_width,
  input  logic [HOLD_W-1:0]     step_hold_ms,
  input  logic [HOLD_W-1:0]     sweep_end_hold_ms,
  output step_t                 step
);

  logic [SWEEP_W-1:0] sweep, sweep_next;
  logic [PIX_W-1:0]   pos, pos_next;
  logic [PIX_W-1:0]   pix, pix_next;

  num_t               w_eff;
  logic [SWEEP_W-1:0] s_cur;
  logic [SWEEP_W-1:0] s_inc;
  num_t               pos_cur;
  logic [PIX_W-1:0]   p_cur;
  kind_t              kind;
  logic               last;
  logic               fend;
  num_t               pos_adv;

  always_comb begin
    w_eff = num_t'(eye_width);
    if (w_eff > num_t'(STRIP_LENGTH - 3)) begin
      w_eff = num_t'(STRIP_LENGTH - 3);
    end

    // restart takes effect on the item that carries it
    s_cur   = restart ? '0 : sweep;
    pos_cur = restart ? sweep_start(KIND_RL, w_eff) : num_t'(pos);
    p_cur   = restart ? '0 : pix;
    s_inc   = s_cur + 3'd1;

    kind = sweep_kind(s_cur);
    last = last_frame(kind, w_eff, pos_cur);
    fend = (p_cur == PIX_W'(STRIP_LENGTH - 1));

    if (last) begin
      pos_adv = sweep_start(sweep_kind(s_inc), w_eff);
    end else if (kind == KIND_RL || kind == KIND_CO) begin
      pos_adv = pos_cur - num_t'(1);
    end else begin
      pos_adv = pos_cur + num_t'(1);
    end

    pix_next   = fend ? '0 : p_cur + 1'b1;
    sweep_next = (fend && last) ? s_inc : s_cur;
    pos_next   = fend ? PIX_W'(pos_adv) : PIX_W'(pos_cur);

    step.pix       = num_t'(p_cur);
    step.pos       = pos_cur;
    step.width     = w_eff;
    step.mirrored  = (kind == KIND_OC || kind == KIND_CO);
    step.frame_end = fend;
    step.seq_end   = fend && last && (s_cur == SWEEP_W'(NUM_SWEEPS - 1));
    step.hold      = '0;
    if (fend) begin
      step.hold = HOLD_OUT_W'(step_hold_ms)
                + (last ? HOLD_OUT_W'(sweep_end_hold_ms) : HOLD_OUT_W'(0));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep <= '0;
      pos   <= PIX_W'(STRIP_LENGTH - RESET_EYE_W - 2);
      pix   <= '0;
    end else if (advance) begin
      sweep <= sweep_next;
      pos   <= pos_next;
      pix   <= pix_next;
    end
  end

endmodule

@@ design/sepg_shader.sv @@
// ----------------------------------------------------------------------------
// sepg_shader
// Classifies one pixel against the eye (and mirrored eye) and picks its
// colour: black, dim (a tenth) or full.
// ----------------------------------------------------------------------------
module sepg_shader import sepg_pkg::*; (
  input  step_t              step,
  input  logic [COLOR_W-1:0] eye_red,
  input  logic [COLOR_W-1:0] eye_green,
  input  logic [COLOR_W-1:0] eye_blue,
  output color_t             color
);

  shade_t shade;
  num_t   m;

  always_comb begin
    m     = num_t'(STRIP_LENGTH) - step.pos;
    shade = SHADE_BLACK;
    // later matches override earlier ones
    if (step.pix == step.pos) begin
      shade = SHADE_DIM;
    end
    if (step.pix >= step.pos + num_t'(1) && step.pix <= step.pos + step.width) begin
      shade = SHADE_FULL;
    end
    if (step.pix == step.pos + step.width + num_t'(1)) begin
      shade = SHADE_DIM;
    end
    if (step.mirrored) begin
      if (step.pix == m) begin
        shade = SHADE_DIM;
      end
      if (step.pix >= m - step.width && step.pix <= m - num_t'(1)) begin
        shade = SHADE_FULL;
      end
      if (step.pix == m - step.width - num_t'(1)) begin
        shade = SHADE_DIM;
      end
    end

    case (shade)
      SHADE_FULL: begin
        color.red   = eye_red;
        color.green = eye_green;
        color.blue  = eye_blue;
      end
      SHADE_DIM: begin
        color.red   = div10(eye_red);
        color.green = div10(eye_green);
        color.blue  = div10(eye_blue);
      end
      default: begin
        color = '0;
      end
    endcase
  end

endmodule

@@ design/scanner_eye_pattern_generator_unit.sv @@
// ----------------------------------------------------------------------------
// scanner_eye_pattern_generator_unit
// Strip scanner (eye sweep) animation generator, one pixel per transfer.
// ----------------------------------------------------------------------------
// Each input transfer produces exactly one pixel result, held in the output
// register from the next cycle; a new input is taken every cycle as long as the
// output register is empty or being drained, so the sustained rate is one
// pixel per cycle. The pixel is computed from the sweep, eye position and
// pixel counters in a single combinational pass ahead of the output register.
// Registers are written through the cfg port (index 0..5: red, green, blue,
// eye width, frame hold, sweep end hold); the port is always ready, and
// writes should only be made while no pixel is pending.
module scanner_eye_pattern_generator_unit import sepg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,

  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  restart,

  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [IDX_W-1:0]      pixel_index,
  output logic [COLOR_W-1:0]    pixel_red,
  output logic [COLOR_W-1:0]    pixel_green,
  output logic [COLOR_W-1:0]    pixel_blue,
  output logic                  frame_end,
  output logic [HOLD_OUT_W-1:0] hold_ms,
  output logic                  sequence_end
);

  logic [COLOR_W-1:0]    eye_red, eye_green, eye_blue;
  logic [EYE_W_BITS-1:0] eye_width;
  logic [HOLD_W-1:0]     step_hold_ms, sweep_end_hold_ms;

  logic   accept;
  step_t  step;
  color_t color;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      eye_red           <= 8'd255;
      eye_green         <= 8'd0;
      eye_blue          <= 8'd0;
      eye_width         <= EYE_W_BITS'(RESET_EYE_W);
      step_hold_ms      <= 16'd10;
      sweep_end_hold_ms <= 16'd50;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_EYE_RED:    eye_red           <= cfg_data[COLOR_W-1:0];
        CFG_EYE_GREEN:  eye_green         <= cfg_data[COLOR_W-1:0];
        CFG_EYE_BLUE:   eye_blue          <= cfg_data[COLOR_W-1:0];
        CFG_EYE_WIDTH:  eye_width         <= cfg_data[EYE_W_BITS-1:0];
        CFG_STEP_HOLD:  step_hold_ms      <= cfg_data[HOLD_W-1:0];
        CFG_SWEEP_HOLD: sweep_end_hold_ms <= cfg_data[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  sepg_sequencer u_sequencer (
    .clk               (clk),
    .rst               (rst),
    .advance           (accept),
    .restart           (restart),
    .eye_width         (eye_width),
    .step_hold_ms      (step_hold_ms),
    .sweep_end_hold_ms (sweep_end_hold_ms),
    .step              (step)
  );

  sepg_shader u_shader (
    .step      (step),
    .eye_red   (eye_red),
    .eye_green (eye_green),
    .eye_blue  (eye_blue),
    .color     (color)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload loads on every accepted input; it holds while the output stalls
  always_ff @(posedge clk) begin
    if (accept) begin
      pixel_index  <= IDX_W'(step.pix);
      pixel_red    <= color.red;
      pixel_green  <= color.green;
      pixel_blue   <= color.blue;
      frame_end    <= step.frame_end;
      hold_ms      <= step.hold;
      sequence_end <= step.seq_end;
    end
  end

endmodule

@@ design/sepg_checker.sv @@
// ----------------------------------------------------------------------------
// sepg_checker
// Port-level assertions for the scanner eye pattern generator, bound to the
// top level.
// ----------------------------------------------------------------------------
module sepg_checker import sepg_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [IDX_W-1:0]      pixel_index,
  input logic                  frame_end,
  input logic [HOLD_OUT_W-1:0] hold_ms,
  input logic                  sequence_end
);

  // hold time only travels with the last pixel of a frame
  a_hold_only_on_frame_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_end |-> hold_ms == '0)
    else $error("hold_ms nonzero off frame end");

  a_seq_end_on_frame_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && sequence_end |-> frame_end)
    else $error("sequence_end without frame_end");

  a_frame_end_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> pixel_index == IDX_W'(STRIP_LENGTH - 1))
    else $error("frame_end on wrong pixel");

  a_out_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel_index) && $stable(hold_ms))
    else $error("output transfer dropped or changed while stalled");

endmodule

bind scanner_eye_pattern_generator_unit sepg_checker u_sepg_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .pixel_index  (pixel_index),
  .frame_end    (frame_end),
  .hold_ms      (hold_ms),
  .sequence_end (sequence_end)
);

@@ test/scanner_eye_pattern_generator_unit_tb.sv @@
// ----------------------------------------------------------------------------
// scanner_eye_pattern_generator_unit_tb
// Self-checking bench for the strip scanner eye generator. It streams pixel
// requests, some carrying restart, under random valid/ready gaps and changes
// the eye settings between phases. It predicts every pixel of the eight-sweep
// sequence and checks each returned pixel, field by field, in order.
// ----------------------------------------------------------------------------
module scanner_eye_pattern_generator_unit_tb;
  import sepg_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int PHASES         = 8;
  localparam int PHASE_PIXELS   = 175;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [IDX_W-1:0]      pix_idx;
    logic [COLOR_W-1:0]    red;
    logic [COLOR_W-1:0]    green;
    logic [COLOR_W-1:0]    blue;
    logic                  frame_end;
    logic [HOLD_OUT_W-1:0] hold;
    logic                  seq_end;
  } pixel_t;

  class pixel_scoreboard;
    logic [COLOR_W-1:0]    red, green, blue;
    logic [EYE_W_BITS-1:0] width_reg;
    logic [HOLD_W-1:0]     frame_hold, sweep_hold;
    logic [SWEEP_W-1:0]    sweep;
    int                    eye_pos;
    int                    pix;
    kind_t                 kinds[NUM_SWEEPS];
    pixel_t                expected_pixels[$];
    int                    errors, pixels_checked, frames, sequences, restarts, reg_writes;

    function new();
      kinds = '{KIND_RL, KIND_LR, KIND_OC, KIND_CO, KIND_LR, KIND_RL, KIND_OC, KIND_CO};
      red = 8'd255;
      green = '0;
      blue = '0;
      width_reg = EYE_W_BITS'(RESET_EYE_W);
      frame_hold = 16'd10;
      sweep_hold = 16'd50;
      sweep = '0;
      pix = 0;
      eye_pos = start_of(sweep, eff_width());
      errors = 0;
      pixels_checked = 0;
      frames = 0;
      sequences = 0;
      restarts = 0;
      reg_writes = 0;
    endfunction

    // clamp so that every sweep keeps at least one frame
    function int eff_width();
      int w;
      w = width_reg;
      if (w > STRIP_LENGTH - 3) w = STRIP_LENGTH - 3;
      return w;
    endfunction

    function int start_of(logic [SWEEP_W-1:0] s, int w);
      case (kinds[s])
        KIND_RL: return STRIP_LENGTH - w - 2;
        KIND_CO: return (STRIP_LENGTH - w) / 2;
        default: return 0;
      endcase
    endfunction

    function bit is_last_frame(logic [SWEEP_W-1:0] s, int w, int p);
      case (kinds[s])
        KIND_RL: return p <= 1;
        KIND_LR: return p >= STRIP_LENGTH - w - 3;
        KIND_OC: return p >= (STRIP_LENGTH - w) / 2;
        default: return p <= 0;
      endcase
    endfunction

    // later writes win: main eye first, then the mirrored one
    function shade_t shade_at(int p, int i, int w, bit mirrored);
      shade_t v;
      int     m;
      v = SHADE_BLACK;
      m = STRIP_LENGTH - i;
      if (p == i) v = SHADE_DIM;
      if (p >= i + 1 && p <= i + w) v = SHADE_FULL;
      if (p == i + w + 1) v = SHADE_DIM;
      if (mirrored) begin
        if (p == m) v = SHADE_DIM;
        if (p >= m - w && p <= m - 1) v = SHADE_FULL;
        if (p == m - w - 1) v = SHADE_DIM;
      end
      return v;
    endfunction

    function logic [COLOR_W-1:0] level(logic [COLOR_W-1:0] full, shade_t v);
      case (v)
        SHADE_FULL: return full;
        SHADE_DIM:  return full / 10;
        default:    return '0;
      endcase
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      reg_writes++;
      case (idx)
        CFG_EYE_RED:    red = data[COLOR_W-1:0];
        CFG_EYE_GREEN:  green = data[COLOR_W-1:0];
        CFG_EYE_BLUE:   blue = data[COLOR_W-1:0];
        CFG_EYE_WIDTH:  width_reg = data[EYE_W_BITS-1:0];
        CFG_STEP_HOLD:  frame_hold = data[HOLD_W-1:0];
        CFG_SWEEP_HOLD: sweep_hold = data[HOLD_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_request(bit restart_req);
      int     w;
      kind_t  k;
      shade_t v;
      bit     fend, lastf;
      pixel_t px;
      w = eff_width();
      if (restart_req) begin
        sweep = '0;
        pix = 0;
        eye_pos = start_of(sweep, w);
        restarts++;
      end
      k = kinds[sweep];
      v = shade_at(pix, eye_pos, w, k == KIND_OC || k == KIND_CO);
      fend = (pix >= STRIP_LENGTH - 1);
      lastf = is_last_frame(sweep, w, eye_pos);
      px = '0;
      px.pix_idx = IDX_W'(pix);
      px.red = level(red, v);
      px.green = level(green, v);
      px.blue = level(blue, v);
      px.frame_end = fend;
      if (fend) begin
        px.hold = HOLD_OUT_W'(frame_hold);
        if (lastf) begin
          px.hold = px.hold + HOLD_OUT_W'(sweep_hold);
          px.seq_end = (sweep == SWEEP_W'(NUM_SWEEPS - 1));
        end
        frames++;
        if (px.seq_end) sequences++;
      end
      expected_pixels.push_back(px);
      // advance pixel, then eye, then sweep
      if (!fend) begin
        pix++;
      end else begin
        pix = 0;
        if (lastf) begin
          sweep = sweep + 1'b1;
          eye_pos = start_of(sweep, w);
        end else if (k == KIND_RL || k == KIND_CO) begin
          eye_pos--;
        end else begin
          eye_pos++;
        end
      end
    endfunction

    function void field_check(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      end
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (expected_pixels.size() == 0) begin
        errors++;
        $error("pixel at index %0d arrived with no request outstanding", got.pix_idx);
        return;
      end
      want = expected_pixels.pop_front();
      pixels_checked++;
      field_check("pixel_index", 32'(want.pix_idx), 32'(got.pix_idx));
      field_check("pixel_red", 32'(want.red), 32'(got.red));
      field_check("pixel_green", 32'(want.green), 32'(got.green));
      field_check("pixel_blue", 32'(want.blue), 32'(got.blue));
      field_check("frame_end", 32'(want.frame_end), 32'(got.frame_end));
      field_check("hold_ms", 32'(want.hold), 32'(got.hold));
      field_check("sequence_end", 32'(want.seq_end), 32'(got.seq_end));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic                  restart;
  logic                  out_valid;
  logic                  out_ready;
  logic [IDX_W-1:0]      pixel_index;
  logic [COLOR_W-1:0]    pixel_red;
  logic [COLOR_W-1:0]    pixel_green;
  logic [COLOR_W-1:0]    pixel_blue;
  logic                  frame_end;
  logic [HOLD_OUT_W-1:0] hold_ms;
  logic                  sequence_end;

  pixel_scoreboard sb;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int pixels_sent = 0;
  int quiet_cycles = 0;

  scanner_eye_pattern_generator_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .restart      (restart),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel_index  (pixel_index),
    .pixel_red    (pixel_red),
    .pixel_green  (pixel_green),
    .pixel_blue   (pixel_blue),
    .frame_end    (frame_end),
    .hold_ms      (hold_ms),
    .sequence_end (sequence_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.set_register(cfg_index, cfg_data);
      if (in_valid && in_ready) sb.note_request(restart);
      if (out_valid && out_ready) begin
        sb.check_pixel(pixel_t'{pix_idx: pixel_index, red: pixel_red, green: pixel_green,
                                blue: pixel_blue, frame_end: frame_end, hold: hold_ms,
                                seq_end: sequence_end});
      end
    end
  end

  // end the run if no transfer of any kind happens for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles", quiet_cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // hold valid high; the caller drops it after the last request
  task automatic send_pixel(bit restart_req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    restart <= restart_req;
    do @(posedge clk); while (!in_ready);
    pixels_sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // stop requests and wait until every pixel has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pixels_checked < pixels_sent) @(posedge clk);
  endtask

  task automatic program_phase(int ph);
    int r;
    int w;
    drain();
    if (ph == 0) begin
      // widest eye saturates; upper data bits must be dropped
      write_reg(CFG_EYE_RED, 16'hFFFF);
      write_reg(CFG_EYE_GREEN, 16'h00FF);
      write_reg(CFG_EYE_BLUE, 16'hFF00);
      write_reg(CFG_EYE_WIDTH, 16'hFFFF);
      write_reg(CFG_STEP_HOLD, 16'hFFFF);
      write_reg(CFG_SWEEP_HOLD, 16'hFFFF);
    end else if (ph == 1) begin
      write_reg(CFG_EYE_RED, '0);
      write_reg(CFG_EYE_GREEN, '0);
      write_reg(CFG_EYE_BLUE, '0);
      write_reg(CFG_EYE_WIDTH, '0);
      write_reg(CFG_STEP_HOLD, '0);
      write_reg(CFG_SWEEP_HOLD, '0);
    end else begin
      // mostly wide eyes so that sweeps are short and the sequence wraps
      r = $urandom_range(99);
      if (r < 60) w = $urandom_range(63, 61);
      else if (r < 85) w = $urandom_range(60, 48);
      else w = $urandom_range(63, 0);
      write_reg(CFG_EYE_RED, 16'($urandom));
      write_reg(CFG_EYE_GREEN, 16'($urandom));
      write_reg(CFG_EYE_BLUE, 16'($urandom));
      write_reg(CFG_EYE_WIDTH, {10'($urandom), 6'(w)});
      write_reg(CFG_STEP_HOLD, ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom));
      write_reg(CFG_SWEEP_HOLD, ($urandom_range(9) == 0) ? 16'h0000 : 16'($urandom));
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    sb = new();
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    restart <= 1'b0;
    send_idle_pct = 36;
    recv_idle_pct = 52;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset settings, restart in the middle of a frame
    send_pixel(1'b0);
    send_pixel(1'b0);
    send_pixel(1'b0);
    send_pixel(1'b1);
    send_pixel(1'b0);
    send_pixel(1'b0);
    drain();
    // writes to unused indexes must leave every setting alone
    write_reg(CFG_SPARE_LO, 16'($urandom));
    write_reg(CFG_SPARE_HI, 16'($urandom));
    write_reg(CFG_EYE_WIDTH, 16'd63);
    write_reg(CFG_EYE_GREEN, 16'd255);
    write_reg(CFG_EYE_BLUE, 16'd127);
    cfg_valid <= 1'b0;
    send_pixel(1'b1);
    repeat (12) send_pixel(1'b0);
    send_pixel(1'b1);
    send_pixel(1'b0);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph < 3) begin
        send_idle_pct = 36;
        recv_idle_pct = 52;
      end else if (ph < 6) begin
        send_idle_pct = 52;
        recv_idle_pct = 36;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      program_phase(ph);
      repeat (PHASE_PIXELS) send_pixel($urandom_range(499) == 0);
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.expected_pixels.size() != 0) begin
      sb.errors++;
      $error("%0d expected pixels never arrived", sb.expected_pixels.size());
    end
    $display("Checked %0d pixels: %0d frames, %0d full eight-sweep sequences, %0d restarts",
             sb.pixels_checked, sb.frames, sb.sequences, sb.restarts);
    $display("%0d register writes over %0d setting phases, %0d mismatches",
             sb.reg_writes, PHASES + 1, sb.errors);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/sepg_pkg.sv
design/sepg_sequencer.sv
design/sepg_shader.sv
design/scanner_eye_pattern_generator_unit.sv
design/sepg_checker.sv
test/scanner_eye_pattern_generator_unit_tb.sv
